>>> src/acet_pkg.sv
// Shared types, constants and helpers for the AABB contact event tracker.
// Used by acet_ctrl, acet_dpath and aabb_contact_event_tracker; no dependencies.
`timescale 1ns / 1ps

package acet_pkg;

    // Collider identifiers and the contact history store
    localparam int ID_COUNT   = 32;
    localparam int ID_W       = 5;
    localparam int HIST_DEPTH = ID_COUNT * ID_COUNT;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int FLAGS_W = 2;
    localparam int EV_W    = 2;

    // Flag bit positions
    localparam int FLAG_ACTIVE = 0;
    localparam int FLAG_DEAD   = 1;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_ENTER = 2'd1;
    localparam logic [EV_W-1:0] EV_STAY  = 2'd2;
    localparam logic [EV_W-1:0] EV_EXIT  = 2'd3;

    // Input word: one collider pair
    typedef struct packed {
        logic        [ID_W-1:0]    left_id;
        logic        [ID_W-1:0]    right_id;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic        [SIZE_W-1:0]  left_w;
        logic        [SIZE_W-1:0]  left_h;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic        [SIZE_W-1:0]  right_w;
        logic        [SIZE_W-1:0]  right_h;
        logic        [FLAGS_W-1:0] left_flags;
        logic        [FLAGS_W-1:0] right_flags;
    } t_in_word;

    // Output word: one event report
    typedef struct packed {
        logic [EV_W-1:0] event_res;
        logic            overlap;
        logic [ID_W-1:0] pair_left;
        logic [ID_W-1:0] pair_right;
    } t_out_word;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_we;  // write zero at the clear counter, advance it
        logic take_in;   // capture input word, start history read
        logic finish;    // update history bit, load output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
    } t_dp_status;

    // History address of an ordered pair
    function automatic logic [HIST_AW-1:0] pair_index(input logic [ID_W-1:0] lid,
                                                      input logic [ID_W-1:0] rid);
        logic [HIST_AW-1:0] base;
        base = HIST_AW'(lid) * HIST_AW'(ID_COUNT);
        return base + HIST_AW'(rid);
    endfunction

    // Pair is tracked: distinct ids, both inside the table
    function automatic logic pair_tracked(input logic [ID_W-1:0] lid,
                                          input logic [ID_W-1:0] rid);
        return (lid != rid) && (32'(lid) < ID_COUNT) && (32'(rid) < ID_COUNT);
    endfunction

endpackage

>>> src/acet_ctrl.sv
// Controller FSM of the contact event tracker: history clear pass, input
// capture, evaluation and output register valid. Depends on acet_pkg.
`timescale 1ns / 1ps

module acet_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  acet_pkg::t_dp_status   i_status,
    output acet_pkg::t_ctrl_cmd    o_cmd
);

    acet_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.clear_we = (r_state == acet_pkg::ST_CLEAR);
        o_cmd.take_in  = (r_state == acet_pkg::ST_IDLE) && i_in_valid;
        o_cmd.finish   = (r_state == acet_pkg::ST_EVAL) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall  = (r_state != acet_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            acet_pkg::ST_CLEAR: begin
                if (i_status.clear_done) n_state = acet_pkg::ST_IDLE;
            end
            acet_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = acet_pkg::ST_EVAL;
            end
            acet_pkg::ST_EVAL: begin
                if (o_cmd.finish) n_state = acet_pkg::ST_IDLE;
            end
            default: n_state = acet_pkg::ST_CLEAR;
        endcase
    end

    // Output word valid: set on load, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish)      n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acet_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/acet_dpath.sv
// Datapath of the contact event tracker: pair history memory, clear counter,
// overlap test, event rules and output register. Depends on acet_pkg.
`timescale 1ns / 1ps

module acet_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acet_pkg::t_in_word    i_in_word,
    input  acet_pkg::t_ctrl_cmd   i_cmd,
    output acet_pkg::t_dp_status  o_status,
    output acet_pkg::t_out_word   o_out_word
);

    // History store, one contact bit per ordered pair
    logic r_hist [acet_pkg::HIST_DEPTH];
    logic r_was;

    logic [acet_pkg::HIST_AW-1:0] r_clr_cnt;
    acet_pkg::t_in_word           r_in;
    logic [acet_pkg::HIST_AW-1:0] r_idx;
    logic                         r_track;
    acet_pkg::t_out_word          r_out;

    logic [acet_pkg::HIST_AW-1:0] wr_addr;
    logic                         wr_en;
    logic                         wr_bit;

    // Overlap test and event rules
    logic signed [acet_pkg::COORD_W:0] dx, dy;
    logic        [acet_pkg::COORD_W:0] mag_x, mag_y;
    logic        [acet_pkg::COORD_W:0] sum_w, sum_h;
    logic                              hit;
    logic                              active, dead;
    logic        [acet_pkg::EV_W-1:0]  ev;
    logic                              new_bit;

    // Clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_status.clear_done = (r_clr_cnt == acet_pkg::HIST_AW'(acet_pkg::HIST_DEPTH - 1));

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_in    <= i_in_word;
            r_idx   <= acet_pkg::pair_index(i_in_word.left_id, i_in_word.right_id);
            r_track <= acet_pkg::pair_tracked(i_in_word.left_id, i_in_word.right_id);
        end
    end

    // Overlap: 2*|d| <= size_a + size_b on both axes
    always_comb begin
        dx    = {r_in.left_x[acet_pkg::COORD_W-1], r_in.left_x}
              - {r_in.right_x[acet_pkg::COORD_W-1], r_in.right_x};
        dy    = {r_in.left_y[acet_pkg::COORD_W-1], r_in.left_y}
              - {r_in.right_y[acet_pkg::COORD_W-1], r_in.right_y};
        mag_x = dx[acet_pkg::COORD_W] ? $unsigned(-dx) : $unsigned(dx);
        mag_y = dy[acet_pkg::COORD_W] ? $unsigned(-dy) : $unsigned(dy);
        sum_w = (acet_pkg::COORD_W+1)'(r_in.left_w) + (acet_pkg::COORD_W+1)'(r_in.right_w);
        sum_h = (acet_pkg::COORD_W+1)'(r_in.left_h) + (acet_pkg::COORD_W+1)'(r_in.right_h);
        hit   = ({mag_x, 1'b0} <= {1'b0, sum_w}) && ({mag_y, 1'b0} <= {1'b0, sum_h});
    end

    // Event rules
    always_comb begin
        active  = r_in.left_flags[acet_pkg::FLAG_ACTIVE] && r_in.right_flags[acet_pkg::FLAG_ACTIVE];
        dead    = r_in.left_flags[acet_pkg::FLAG_DEAD] || r_in.right_flags[acet_pkg::FLAG_DEAD];
        ev      = acet_pkg::EV_NONE;
        new_bit = r_was;
        if (r_track) begin
            if (!active) begin
                if (r_was) begin
                    ev      = acet_pkg::EV_EXIT;
                    new_bit = 1'b0;
                end
            end else if (hit) begin
                if (r_was) begin
                    if (dead) begin
                        ev      = acet_pkg::EV_EXIT;
                        new_bit = 1'b0;
                    end else begin
                        ev = acet_pkg::EV_STAY;
                    end
                end else if (!dead) begin
                    ev      = acet_pkg::EV_ENTER;
                    new_bit = 1'b1;
                end
            end else if (r_was) begin
                ev      = acet_pkg::EV_EXIT;
                new_bit = 1'b0;
            end
        end
    end

    // History write port: clear pass or pair update
    always_comb begin
        wr_en   = i_cmd.clear_we || (i_cmd.finish && r_track);
        wr_addr = i_cmd.clear_we ? r_clr_cnt : r_idx;
        wr_bit  = i_cmd.clear_we ? 1'b0 : new_bit;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_bit;
        end
        if (i_cmd.take_in) begin
            r_was <= r_hist[acet_pkg::pair_index(i_in_word.left_id, i_in_word.right_id)];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.event_res  <= ev;
            r_out.overlap    <= hit;
            r_out.pair_left  <= r_in.left_id;
            r_out.pair_right <= r_in.right_id;
        end
    end

    assign o_out_word = r_out;

endmodule

>>> src/aabb_contact_event_tracker.sv
// Top level of the AABB contact event tracker: controller plus datapath.
// Depends on acet_pkg, acet_ctrl and acet_dpath.
`timescale 1ns / 1ps

// Takes one collider pair per word and returns one event word (none, enter,
// stay, exit, plus the overlap flag and the echoed ids) for each. A contact
// bit per ordered pair lives in a 1024-entry single-port history memory.
// After reset the block sweeps that memory to zero, one entry per cycle, and
// holds o_in_stall high until the sweep is done. Each pair is captured with
// its history bit read, then evaluated with the bit written back once the
// output register is free; o_in_stall holds off the next pair until then.
// The output register lets the next pair be captured while a result waits.
module aabb_contact_event_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  acet_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output acet_pkg::t_out_word  o_out_word
);

    acet_pkg::t_ctrl_cmd  cmd;
    acet_pkg::t_dp_status status;

    // Sequencing
    acet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // History, overlap test and event rules
    acet_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

endmodule
